### sv/bcdtod_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcdtod_pkg
// Shared types, constants and BCD helper functions for the time-of-day clock.
// ---------------------------------------------------------------------------
package bcdtod_pkg;

	localparam int TpsW = 30;
	localparam int CptW = 20;
	localparam int AccW = 32;

	localparam logic [TpsW-1:0] TPS_RESET = 30'd20000000;
	localparam logic [CptW-1:0] CPT_RESET = 20'd4096;

	localparam logic [7:0] HOURS_WRAP  = 8'h24;
	localparam logic [7:0] MINSEC_WRAP = 8'h60;

	// input item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	// configuration register indexes
	localparam logic REG_TPS = 1'b0;
	localparam logic REG_CPT = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] set_hours;
		logic [7:0] set_minutes;
		logic [7:0] set_seconds;
	} item_t;

	typedef struct packed {
		logic [5:0] hours_bcd;
		logic [6:0] minutes_bcd;
		logic [6:0] seconds_bcd;
		logic       second_elapsed;
		logic       set_rejected;
	} result_t;

	typedef struct packed {
		logic            index;
		logic [TpsW-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [TpsW-1:0] ticks_per_second;
		logic [CptW-1:0] counts_per_tick;
	} cfg_t;

	// two-digit bcd increment with wrap to zero
	function automatic logic [7:0] bcd_inc(input logic [7:0] v, input logic [7:0] wrap);
		logic [7:0] x;
		x = v + 8'd1;
		if (x[3:0] >= 4'd10) begin
			x = x + 8'd6;
		end
		if (x >= wrap) begin
			x = 8'd0;
		end
		return x;
	endfunction

	function automatic logic bcd_ok(input logic [7:0] v, input logic [7:0] wrap);
		return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9) && (v < wrap);
	endfunction

endpackage

### sv/bcdtod_chan_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcdtod_chan_if
// Valid/ready channel carrying one payload per beat.
// ---------------------------------------------------------------------------
interface bcdtod_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/bcdtod_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcdtod_cfg_regs
// Configuration register file: ticks per second and counts per tick.
// ---------------------------------------------------------------------------
module bcdtod_cfg_regs
	import bcdtod_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  cfg_wr_t wr,
	output cfg_t    cfg
);

	logic [TpsW-1:0] tps_q;
	logic [CptW-1:0] cpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			cpt_q <= CPT_RESET;
		end else if (wr_en) begin
			unique case (wr.index)
				REG_TPS: tps_q <= wr.value;
				REG_CPT: cpt_q <= wr.value[CptW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ticks_per_second = tps_q;
	assign cfg.counts_per_tick  = cpt_q;

endmodule

### sv/bcdtod_time_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcdtod_time_core
// Accumulator, second threshold and bcd time state; next-state and result.
// ---------------------------------------------------------------------------
module bcdtod_time_core
	import bcdtod_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [AccW-1:0] acc_q;
	logic [AccW-1:0] thr_q;
	logic [5:0]      hours_q;
	logic [6:0]      minutes_q;
	logic [6:0]      seconds_q;

	logic [AccW-1:0] acc_d;
	logic [AccW-1:0] thr_d;
	logic [7:0]      hours_d;
	logic [7:0]      minutes_d;
	logic [7:0]      seconds_d;
	logic            hit;
	logic            set_ok;
	logic [7:0]      sec_inc;
	logic [7:0]      min_inc;
	logic [7:0]      hr_inc;

	always_comb begin
		hit     = (acc_q >= thr_q);
		set_ok  = bcd_ok(item.set_hours, HOURS_WRAP) && bcd_ok(item.set_minutes, MINSEC_WRAP)
			&& bcd_ok(item.set_seconds, MINSEC_WRAP);
		sec_inc = bcd_inc({1'b0, seconds_q}, MINSEC_WRAP);
		min_inc = bcd_inc({1'b0, minutes_q}, MINSEC_WRAP);
		hr_inc  = bcd_inc({2'b0, hours_q}, HOURS_WRAP);

		acc_d     = acc_q;
		thr_d     = thr_q;
		hours_d   = {2'b0, hours_q};
		minutes_d = {1'b0, minutes_q};
		seconds_d = {1'b0, seconds_q};
		res.second_elapsed = 1'b0;
		res.set_rejected   = 1'b0;

		unique case (item.kind)
			KIND_TICK: begin
				if (hit) begin
					thr_d = thr_q + {{(AccW-TpsW){1'b0}}, cfg.ticks_per_second} - acc_q;
					res.second_elapsed = 1'b1;
					seconds_d = sec_inc;
					if (sec_inc == 8'd0) begin
						minutes_d = min_inc;
						if (min_inc == 8'd0) begin
							hours_d = hr_inc;
						end
					end
				end
				acc_d = (hit ? '0 : acc_q) + {{(AccW-CptW){1'b0}}, cfg.counts_per_tick};
			end
			KIND_SET: begin
				if (set_ok) begin
					hours_d   = item.set_hours;
					minutes_d = item.set_minutes;
					seconds_d = item.set_seconds;
					acc_d     = '0;
					thr_d     = {{(AccW-TpsW){1'b0}}, cfg.ticks_per_second};
				end else begin
					res.set_rejected = 1'b1;
				end
			end
			default: ;
		endcase

		res.hours_bcd   = hours_d[5:0];
		res.minutes_bcd = minutes_d[6:0];
		res.seconds_bcd = seconds_d[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			thr_q     <= {{(AccW-TpsW){1'b0}}, TPS_RESET};
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
		end else if (step) begin
			acc_q     <= acc_d;
			thr_q     <= thr_d;
			hours_q   <= hours_d[5:0];
			minutes_q <= minutes_d[6:0];
			seconds_q <= seconds_d[6:0];
		end
	end

endmodule

### sv/bcd_time_of_day_clock.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_time_of_day_clock
// 24-hour bcd real-time clock advanced by tick beats, loadable by set beats.
// ---------------------------------------------------------------------------
//  channel     dir  payload                                   role
//  item_in     in   kind, set_hours, set_minutes, set_seconds tick or set time
//  result_out  out  hours/minutes/seconds_bcd, flags          one per item
//  cfg_wr      in   index, value                              register write
//
//  one item per cycle sustained while results are taken; an item is held in the
//  input register until it advances; its result then enters the output register
//  the whole update (32-bit compare, threshold reload, bcd carry) is one
//  combinational pass between the input and output registers
//  reset: time 00:00:00, accumulator 0, threshold and registers at defaults
//  a stalled result holds the output register; the input register still
//  drains into it as soon as it is taken, so ready drops only when both full
// ---------------------------------------------------------------------------
module bcd_time_of_day_clock
	import bcdtod_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	bcdtod_chan_if.sink          item_in,
	bcdtod_chan_if.source        result_out,
	bcdtod_chan_if.sink          cfg_wr
);

	// input register
	logic    valid_s1;
	item_t   item_s1;
	// output register
	logic    out_valid_q;
	result_t res_q;

	cfg_t    cfg;
	result_t core_res;
	logic    in_fire;
	logic    advance;

	// item moves from the input register to the output register
	assign advance = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign in_fire = item_in.valid && item_in.ready;

	// registers are always writable
	assign cfg_wr.ready = 1'b1;

	bcdtod_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr.valid),
		.wr     (cfg_wr.data),
		.cfg    (cfg)
	);

	bcdtod_time_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_fire || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && !result_out.ready);
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_in.data;
		end
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = res_q;

endmodule

### sv/bcdtod_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcdtod_checker
// Port-level checks on the result channel of the time-of-day clock.
// ---------------------------------------------------------------------------
module bcdtod_checker
	import bcdtod_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	// a stalled beat stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled beat keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// a beat never flags both a second step and a rejected set
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.second_elapsed && out_data.set_rejected))
		else $error("second_elapsed and set_rejected both set");

	// reported time is always a legal bcd time of day
	a_time_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hours_bcd <= 6'h23) && (out_data.hours_bcd[3:0] <= 4'd9)
			&& (out_data.minutes_bcd <= 7'h59) && (out_data.minutes_bcd[3:0] <= 4'd9)
			&& (out_data.seconds_bcd <= 7'h59) && (out_data.seconds_bcd[3:0] <= 4'd9))
		else $error("illegal bcd time reported");

endmodule

bind bcd_time_of_day_clock bcdtod_checker u_bcdtod_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_data  (result_out.data)
);

### tb/bcd_time_of_day_clock_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_time_of_day_clock_tb
// Self-checking bench for the bcd time-of-day clock: a directed table, then
// random tick and set beats under several register settings, each result
// matched to a typed row or an in-bench time keeper; random stalls on both sides.
// ---------------------------------------------------------------------------
module bcd_time_of_day_clock_tb;
	import bcdtod_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int NUM_DIRECTED    = 34;
	localparam int NUM_PHASES      = 7;
	localparam int ITEMS_PER_PHASE = 64;
	localparam int HOLD_CYCLES     = 60;
	localparam int SETTLE_CYCLES   = 10;

	// directed table row kinds and how a row is checked
	typedef enum logic [1:0] {ROW_TICK, ROW_SET, ROW_CONFIG} row_op_t;
	typedef enum logic {CHK_PREDICT, CHK_TYPED} check_t;

	typedef struct {
		row_op_t     op;
		logic [23:0] hms;        // set fields {h, m, s}; don't-care for a tick
		logic [29:0] tps;        // config rows only
		logic [19:0] cpt;
		check_t      chk;
		logic [23:0] want_hms;   // typed rows only
		logic [1:0]  want_flags; // {second_elapsed, set_rejected}
	} stim_row_t;

	logic clk;
	logic arst_n;

	bcdtod_chan_if #(.payload_t(item_t))   item_ch ();
	bcdtod_chan_if #(.payload_t(result_t)) result_ch ();
	bcdtod_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();

	bcd_time_of_day_clock uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (result_ch),
		.cfg_wr     (cfg_ch)
	);

	// time keeper state, mirrors what the block should hold
	logic [AccW-1:0] tick_accum;
	logic [AccW-1:0] sec_threshold;
	logic [7:0]      cur_hours;
	logic [7:0]      cur_minutes;
	logic [7:0]      cur_seconds;
	logic [TpsW-1:0] cur_tps;
	logic [CptW-1:0] cur_cpt;

	result_t     expected_times [$];
	int unsigned errors_seen = 0;
	int unsigned cycle_count = 0;

	// idling knobs, set at a rising edge by set_idling; the hold is taken up at the falling edge
	int unsigned send_idle_pct = 38;
	int unsigned recv_idle_pct = 54;
	bit          hold_armed = 1'b0;
	int unsigned hold_left = 0;

	// directed table: reset values, every rejection reason, carries through
	// digits, minute and hour, midnight, and the register extremes including
	// a step larger than a second and zero registers
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{ROW_TICK,   24'hFF_FF_FF, 30'd0, 20'd0, CHK_TYPED,   24'h00_00_00, 2'b00},
		'{ROW_SET,    24'h23_59_59, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b00},
		'{ROW_SET,    24'h24_00_00, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_SET,    24'h00_60_00, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_SET,    24'h00_00_60, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_SET,    24'h0A_00_00, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_SET,    24'h00_5A_00, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_SET,    24'h00_00_0F, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_SET,    24'hFF_FF_FF, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_59, 2'b01},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_CONFIG, 24'h00_00_00, 30'd1, 20'd1, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_SET,    24'h23_59_58, 30'd0, 20'd0, CHK_TYPED,   24'h23_59_58, 2'b00},
		'{ROW_TICK,   24'hA5_C3_7E, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h5A_3C_81, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_SET,    24'h09_59_59, 30'd0, 20'd0, CHK_TYPED,   24'h09_59_59, 2'b00},
		'{ROW_TICK,   24'hFF_00_FF, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_FF_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_SET,    24'h19_09_59, 30'd0, 20'd0, CHK_TYPED,   24'h19_09_59, 2'b00},
		'{ROW_TICK,   24'h12_34_56, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'hED_CB_A9, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_CONFIG, 24'h00_00_00, 30'h3FFF_FFFF, 20'hF_FFFF, CHK_PREDICT,
			24'h00_00_00, 2'b00},
		'{ROW_SET,    24'h12_00_00, 30'd0, 20'd0, CHK_TYPED,   24'h12_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_CONFIG, 24'h00_00_00, 30'd2, 20'hF_FFFF, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_CONFIG, 24'h00_00_00, 30'd0, 20'd5, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_CONFIG, 24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00},
		'{ROW_TICK,   24'h00_00_00, 30'd0, 20'd0, CHK_PREDICT, 24'h00_00_00, 2'b00}
	};

	// register settings for the random phases; the last one is drawn at random
	logic [TpsW-1:0] phase_tps [NUM_PHASES] = '{
		30'd7, 30'd1, 30'd100, 30'h3FFF_FFFF, 30'd5, 30'd2, 30'd0
	};
	logic [CptW-1:0] phase_cpt [NUM_PHASES] = '{
		20'd3, 20'd1, 20'd37, 20'hF_FFFF, 20'd9, 20'd1, 20'd0
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// global watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bcd_time_of_day_clock_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// time keeper
	// ------------------------------------------------------------------

	// next two-digit bcd value, back to zero at the limit
	function automatic logic [7:0] bcd_next(input logic [7:0] v, input logic [7:0] limit);
		logic [7:0] n;
		n = (v[3:0] == 4'd9) ? {v[7:4] + 4'd1, 4'd0} : v + 8'd1;
		return (n >= limit) ? 8'd0 : n;
	endfunction

	function automatic logic bcd_legal(input logic [7:0] v, input logic [7:0] limit);
		return (v < limit) && (v[3:0] < 4'd10) && (v[7:4] < 4'd10);
	endfunction

	function automatic result_t step_clock(input item_t beat);
		result_t r;
		r = '0;
		if (beat.kind == KIND_TICK) begin
			// a full second has built up: carry the overshoot into the next one
			if (tick_accum >= sec_threshold) begin
				sec_threshold = sec_threshold + AccW'(cur_tps) - tick_accum;
				tick_accum = '0;
				r.second_elapsed = 1'b1;
				cur_seconds = bcd_next(cur_seconds, MINSEC_WRAP);
				if (cur_seconds == 8'd0) begin
					cur_minutes = bcd_next(cur_minutes, MINSEC_WRAP);
					if (cur_minutes == 8'd0) begin
						cur_hours = bcd_next(cur_hours, HOURS_WRAP);
					end
				end
			end
			tick_accum = tick_accum + AccW'(cur_cpt);
		end else if (bcd_legal(beat.set_hours, HOURS_WRAP)
				&& bcd_legal(beat.set_minutes, MINSEC_WRAP)
				&& bcd_legal(beat.set_seconds, MINSEC_WRAP)) begin
			cur_hours = beat.set_hours;
			cur_minutes = beat.set_minutes;
			cur_seconds = beat.set_seconds;
			tick_accum = '0;
			sec_threshold = AccW'(cur_tps);
		end else begin
			// bad time: state untouched, flag raised
			r.set_rejected = 1'b1;
		end
		r.hours_bcd = cur_hours[5:0];
		r.minutes_bcd = cur_minutes[6:0];
		r.seconds_bcd = cur_seconds[6:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers, all entered and left at a falling edge
	// ------------------------------------------------------------------

	function automatic logic [7:0] to_bcd(input int unsigned n);
		return 8'(((n / 10) << 4) | (n % 10));
	endfunction

	// mostly ticks with junk in the set fields; sets lean toward the end of
	// a minute so carries into minutes, hours and midnight come often
	function automatic item_t random_beat();
		item_t b;
		int unsigned pick;
		b = item_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 78) begin
			b.kind = KIND_TICK;
		end else if (pick < 92) begin
			b.kind = KIND_SET;
			b.set_hours = ($urandom_range(0, 3) == 0) ? 8'h23 : to_bcd($urandom_range(0, 23));
			b.set_minutes = $urandom_range(0, 1) ? 8'h59 : to_bcd($urandom_range(0, 59));
			b.set_seconds = to_bcd($urandom_range(45, 59));
		end else begin
			// raw fields, almost always a rejected set
			b.kind = KIND_SET;
		end
		return b;
	endfunction

	// offer one beat, predict its result on acceptance
	task automatic send_item(input item_t beat, input bit use_typed, input result_t typed_want);
		result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= beat;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		predicted = step_clock(beat);
		expected_times.push_back(use_typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (expected_times.size() != 0) @(negedge clk);
	endtask

	// both registers back to back, only while the block is idle
	task automatic write_config(input logic [TpsW-1:0] tps, input logic [CptW-1:0] cpt);
		cfg_wr_t writes [2];
		writes[0] = '{index: REG_TPS, value: tps};
		writes[1] = '{index: REG_CPT, value: TpsW'(cpt)};
		foreach (writes[i]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.data <= writes[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			if (writes[i].index == REG_TPS) begin
				cur_tps = tps;
			end else begin
				cur_cpt = cpt;
			end
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// knobs change at a rising edge so the falling-edge drivers read them cleanly
	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct,
			input bit arm_hold);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		hold_armed = arm_hold;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// ready moves at the falling edge; an armed hold keeps it low for a long
	// stretch so the block fills and pushes back on the item channel
	always @(negedge clk) begin
		if (hold_armed) begin
			hold_armed = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors_seen++;
		end
	endtask

	// each result beat against the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got = result_ch.data;
			if (expected_times.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors_seen++;
			end else begin
				want = expected_times.pop_front();
				check_field("hours_bcd", 8'(want.hours_bcd), 8'(got.hours_bcd));
				check_field("minutes_bcd", 8'(want.minutes_bcd), 8'(got.minutes_bcd));
				check_field("seconds_bcd", 8'(want.seconds_bcd), 8'(got.seconds_bcd));
				check_field("second_elapsed", 8'(want.second_elapsed),
					8'(got.second_elapsed));
				check_field("set_rejected", 8'(want.set_rejected), 8'(got.set_rejected));
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		item_t           beat;
		result_t         want;
		logic [TpsW-1:0] tps;
		logic [CptW-1:0] cpt;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;

		// time keeper at its reset values
		tick_accum = '0;
		sec_threshold = AccW'(TPS_RESET);
		cur_hours = 8'd0;
		cur_minutes = 8'd0;
		cur_seconds = 8'd0;
		cur_tps = TPS_RESET;
		cur_cpt = CPT_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, sender 38 and receiver 54 percent idle
		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_CONFIG) begin
				wait_drained();
				write_config(directed_rows[i].tps, directed_rows[i].cpt);
			end else begin
				beat.kind = (directed_rows[i].op == ROW_SET) ? KIND_SET : KIND_TICK;
				{beat.set_hours, beat.set_minutes, beat.set_seconds} = directed_rows[i].hms;
				want.hours_bcd = directed_rows[i].want_hms[21:16];
				want.minutes_bcd = directed_rows[i].want_hms[14:8];
				want.seconds_bcd = directed_rows[i].want_hms[6:0];
				{want.second_elapsed, want.set_rejected} = directed_rows[i].want_flags;
				send_item(beat, directed_rows[i].chk == CHK_TYPED, want);
			end
		end

		// random phases: idling swaps at phase 3, stops at phase 5 where the
		// receiver also takes its long hold-off
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			if (ph == 3) begin
				set_idling(54, 38, 1'b0);
			end
			if (ph == NUM_PHASES - 1) begin
				tps = TpsW'($urandom_range(1, 64));
				cpt = CptW'($urandom_range(1, int'(tps)));
			end else begin
				tps = phase_tps[ph];
				cpt = phase_cpt[ph];
			end
			write_config(tps, cpt);
			if (ph == 5) begin
				set_idling(0, 0, 1'b1);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_item(random_beat(), 1'b0, '0);
			end
		end

		// let stragglers show up, then report
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors_seen == 0) begin
			$display("bcd_time_of_day_clock_tb OK");
		end else begin
			$display("bcd_time_of_day_clock_tb NOT OK");
		end
		$finish;
	end

endmodule

### filelist.f
sv/bcdtod_pkg.sv
sv/bcdtod_chan_if.sv
sv/bcdtod_cfg_regs.sv
sv/bcdtod_time_core.sv
sv/bcd_time_of_day_clock.sv
sv/bcdtod_checker.sv
tb/bcd_time_of_day_clock_tb.sv
